// ===== design/sgpw_pkg.sv =====
`timescale 1ns / 1ps

package sgpw_pkg;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_SCAD  = 2'd0;
    localparam mode_t MODE_CONST = 2'd1;
    localparam mode_t MODE_MCP   = 2'd2;
    localparam mode_t MODE_EXP   = 2'd3;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t REG_VAR_LAMBDA = 3'd0;
    localparam cfg_idx_t REG_GRP_LAMBDA = 3'd1;
    localparam cfg_idx_t REG_VAR_TAU    = 3'd2;
    localparam cfg_idx_t REG_GRP_TAU    = 3'd3;
    localparam cfg_idx_t REG_VAR_GAMMA  = 3'd4;
    localparam cfg_idx_t REG_GRP_GAMMA  = 3'd5;
    localparam cfg_idx_t REG_VAR_MODE   = 3'd6;
    localparam cfg_idx_t REG_GRP_MODE   = 3'd7;

    // quotient width of every divider, and its register count
    localparam int Q_W     = 31;
    localparam int DIV_LAT = Q_W + 1;

    localparam logic [30:0] ONE_Q16    = 31'd65536;
    localparam logic [30:0] THREE_Q16  = 31'd196608;
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
    localparam logic [30:0] LN2_Q30    = 31'd744261118;
    localparam logic [30:0] EXP_ZERO_X = 31'd1572864;
    localparam logic [30:0] PEN_MAX    = 31'h7FFF_FFFF;

    // 2^-(idx/2^tbits) in Q0.30, truncated Taylor series of e^-(t*ln2)
    function automatic logic [30:0] exp_rom_entry(input int unsigned idx,
                                                  input int unsigned tbits);
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        int          n;
        t    = 64'(idx) << (30 - tbits);
        u    = (t * 64'(LN2_Q30)) >> 30;
        term = 64'(ONE_Q30);
        pos  = 64'(ONE_Q30);
        neg  = '0;
        for (n = 1; n <= 14; n++) begin
            term = (term * u) >> 30;
            case (n)
                2:  term = term / 2;
                3:  term = term / 3;
                4:  term = term / 4;
                5:  term = term / 5;
                6:  term = term / 6;
                7:  term = term / 7;
                8:  term = term / 8;
                9:  term = term / 9;
                10: term = term / 10;
                11: term = term / 11;
                12: term = term / 12;
                13: term = term / 13;
                14: term = term / 14;
                default: term = term;
            endcase
            if (n % 2 == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        if (neg > pos)
            return '0;
        pos = pos - neg;
        if (pos > 64'(ONE_Q30))
            return ONE_Q30;
        return pos[30:0];
    endfunction

endpackage

// ===== design/sgpw_div.sv =====
`timescale 1ns / 1ps

module sgpw_div import sgpw_pkg::*;
#(
    parameter int TAG_W = 2
)
(
    input  logic               clk,
    input  logic               en,
    input  logic [2*Q_W:0]     num,
    input  logic [Q_W-1:0]     den,
    input  logic [TAG_W-1:0]   tag,
    output logic [Q_W-1:0]     quot,
    output logic               ovf,
    output logic [TAG_W-1:0]   tag_out
);

    logic [Q_W-1:0]   rem_reg [0:DIV_LAT-1];
    logic [Q_W-1:0]   low_reg [0:DIV_LAT-1];
    logic [Q_W-1:0]   q_reg   [0:DIV_LAT-1];
    logic [Q_W-1:0]   den_reg [0:DIV_LAT-1];
    logic             ovf_reg [0:DIV_LAT-1];
    logic [TAG_W-1:0] tag_reg [0:DIV_LAT-1];
    logic [Q_W:0]     head;

    assign head = num[2*Q_W:Q_W];

    // quotient needs more than Q_W bits when the top half already reaches den
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= head[Q_W-1:0];
            low_reg[0] <= num[Q_W-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= (head >= {1'b0, den});
            tag_reg[0] <= tag;
        end
    end

    for (genvar s = 0; s < Q_W; s++)
    begin : g_step
        logic [Q_W:0] trial;
        logic [Q_W:0] diff;
        logic         ge;

        assign trial = {rem_reg[s], low_reg[s][Q_W-1]};
        assign ge    = (trial >= {1'b0, den_reg[s]});
        assign diff  = trial - {1'b0, den_reg[s]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
                low_reg[s+1] <= {low_reg[s][Q_W-2:0], 1'b0};
                q_reg[s+1]   <= {q_reg[s][Q_W-2:0], ge};
                den_reg[s+1] <= den_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign quot    = q_reg[DIV_LAT-1];
    assign ovf     = ovf_reg[DIV_LAT-1];
    assign tag_out = tag_reg[DIV_LAT-1];

endmodule

// ===== design/sparse_group_penalty_weight.sv =====
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// cfg      in         cfg_we                 cfg_index, cfg_data
// in       in         in_valid / in_stall    old_coef, correlation, group_norm, active_norm
// out      out        out_valid / out_stall  penalty
//
// One beat per cycle in, one per cycle out while no output beat is held; the path
// to out_valid runs through two 31-step restoring divider pipelines in series.
// Reset clears valid bits and loads the default registers.
// A held output beat freezes every stage; in_stall rises only then.

module sparse_group_penalty_weight import sgpw_pkg::*;
#(
    parameter int EXP_TABLE_BITS = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] old_coef,
    input  logic signed [31:0] correlation,
    input  logic [30:0]        group_norm,
    input  logic [30:0]        active_norm,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [30:0]        penalty
);

    localparam int ROM_N     = 1 << EXP_TABLE_BITS;
    localparam int DW        = 30 - EXP_TABLE_BITS;
    localparam int LVL_LAST  = 2 + DIV_LAT + 7;
    localparam int FIN_LAST  = LVL_LAST + 1 + DIV_LAT;

    logic [30:0] var_lambda_reg, grp_lambda_reg, var_tau_reg, grp_tau_reg;
    logic [30:0] var_gamma_reg, grp_gamma_reg;
    mode_t       var_mode_reg, grp_mode_reg;

    logic        en;
    logic        vld_reg [0:FIN_LAST];
    logic [31:0] z_d_reg [0:LVL_LAST];
    logic [30:0] gn_d_reg [0:LVL_LAST];
    logic [31:0] theta_v_reg;
    logic [30:0] act_reg;
    logic [31:0] coef_u, corr_u;
    logic [30:0] exp_rom [0:ROM_N-1];
    logic [30:0] pen_lvl [0:1];

    logic [62:0] fp_reg;
    logic [30:0] gn_reg, pv_reg, pg_reg;
    logic        gz_reg;
    logic [30:0] fq;
    logic        fovf;
    logic [62:0] ftag;
    logic [31:0] sum_plain, sum_div;
    logic [30:0] penalty_next;
    logic [30:0] penalty_reg;
    logic        out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;
    assign coef_u   = old_coef;
    assign corr_u   = correlation;

    for (genvar i = 0; i < ROM_N; i++)
    begin : g_rom
        assign exp_rom[i] = exp_rom_entry(i, EXP_TABLE_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_lambda_reg <= ONE_Q16;
            grp_lambda_reg <= ONE_Q16;
            var_tau_reg    <= ONE_Q16;
            grp_tau_reg    <= ONE_Q16;
            var_gamma_reg  <= THREE_Q16;
            grp_gamma_reg  <= THREE_Q16;
            var_mode_reg   <= MODE_CONST;
            grp_mode_reg   <= MODE_CONST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VAR_LAMBDA: var_lambda_reg <= cfg_data;
                REG_GRP_LAMBDA: grp_lambda_reg <= cfg_data;
                REG_VAR_TAU:    var_tau_reg    <= cfg_data;
                REG_GRP_TAU:    grp_tau_reg    <= cfg_data;
                REG_VAR_GAMMA:  var_gamma_reg  <= cfg_data;
                REG_GRP_GAMMA:  grp_gamma_reg  <= cfg_data;
                REG_VAR_MODE:   var_mode_reg   <= cfg_data[1:0];
                REG_GRP_MODE:   grp_mode_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // valid bits walk alongside every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= FIN_LAST; s++)
                vld_reg[s] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= FIN_LAST; s++)
                vld_reg[s] <= vld_reg[s-1];
            out_valid_reg <= vld_reg[FIN_LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_v_reg <= coef_u[31] ? (~coef_u + 32'd1) : coef_u;
            act_reg     <= active_norm;
            z_d_reg[0]  <= corr_u[31] ? (~corr_u + 32'd1) : corr_u;
            gn_d_reg[0] <= group_norm;
            for (int s = 1; s <= LVL_LAST; s++)
            begin
                z_d_reg[s]  <= z_d_reg[s-1];
                gn_d_reg[s] <= gn_d_reg[s-1];
            end
        end
    end

    // level 0 is the variable penalty, level 1 the group penalty
    for (genvar lv = 0; lv < 2; lv++)
    begin : g_lvl
        logic [30:0]     lam, gam, tau;
        mode_t           mode;
        logic [31:0]     th;

        logic [61:0]     gl_reg;
        logic [62:0]     tt_reg;
        logic [31:0]     th1_reg;

        logic [47:0]     th16;
        logic [62:0]     num_next;
        logic [30:0]     den_next;
        logic [62:0]     num_reg;
        logic [30:0]     den_reg;
        logic            cond_reg, le_reg;

        logic [30:0]     q;
        logic            q_ovf;
        logic [1:0]      q_tag;

        logic [51:0]     y_prod;
        logic [30:0]     pen_n_next;
        logic [35:0]     y_reg;
        logic            zero1_reg;
        logic [30:0]     pen_n1_reg;

        logic [EXP_TABLE_BITS-1:0] idx;
        logic [DW-1:0]   d;
        logic [DW+29:0]  du_prod;
        logic [DW-1:0]   u_reg, u3_reg;
        logic [30:0]     rom_reg, rom3_reg, rom4_reg;
        logic [4:0]      k2_reg, k3_reg, k4_reg, k5_reg, k6_reg;
        logic            zero2_reg, zero3_reg, zero4_reg, zero5_reg, zero6_reg;
        logic [30:0]     pen_n2_reg, pen_n3_reg, pen_n4_reg, pen_n5_reg, pen_n6_reg;

        logic [2*DW-1:0] uu_reg;
        logic [31:0]     p_sum;
        logic [30:0]     p_reg;
        logic [61:0]     m_prod;
        logic [30:0]     m_reg;
        logic [61:0]     lm_reg;
        logic [5:0]      sh;
        logic [61:0]     lm_sh;
        logic [30:0]     pen_reg;

        assign lam  = (lv == 0) ? var_lambda_reg : grp_lambda_reg;
        assign gam  = (lv == 0) ? var_gamma_reg  : grp_gamma_reg;
        assign tau  = (lv == 0) ? var_tau_reg    : grp_tau_reg;
        assign mode = (lv == 0) ? var_mode_reg   : grp_mode_reg;
        assign th   = (lv == 0) ? theta_v_reg    : {1'b0, act_reg};

        assign th16 = {th1_reg, 16'd0};

        always_comb
        begin
            unique case (mode)
                MODE_MCP:
                begin
                    num_next = 63'(th16);
                    den_next = gam;
                end
                MODE_SCAD:
                begin
                    num_next = {1'b0, gl_reg - 62'(th16)};
                    den_next = gam - ONE_Q16;
                end
                MODE_EXP:
                begin
                    num_next = tt_reg;
                    den_next = lam;
                end
                MODE_CONST:
                begin
                    num_next = '0;
                    den_next = lam;
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                gl_reg   <= 62'(gam) * 62'(lam);
                tt_reg   <= 63'(tau) * 63'(th);
                th1_reg  <= th;
                num_reg  <= num_next;
                den_reg  <= den_next;
                cond_reg <= (62'(th16) < gl_reg);
                le_reg   <= (th1_reg <= {1'b0, lam});
            end
        end

        sgpw_div #(.TAG_W(2)) u_div
        (
            .clk     (clk),
            .en      (en),
            .num     (num_reg),
            .den     (den_reg),
            .tag     ({cond_reg, le_reg}),
            .quot    (q),
            .ovf     (q_ovf),
            .tag_out (q_tag)
        );

        assign y_prod = 52'(q[20:0]) * 52'(LOG2E_Q30);

        // q_tag[1]: below the cutoff, q_tag[0]: theta within lambda
        always_comb
        begin
            unique case (mode)
                MODE_CONST: pen_n_next = lam;
                MODE_MCP:   pen_n_next = q_tag[1] ? (lam - q) : '0;
                MODE_SCAD:  pen_n_next = q_tag[0] ? lam : (q_tag[1] ? q : '0);
                MODE_EXP:   pen_n_next = '0;
            endcase
        end

        assign idx     = y_reg[29 -: EXP_TABLE_BITS];
        assign d       = y_reg[DW-1:0];
        assign du_prod = (DW+30)'(d) * (DW+30)'(LN2_Q30);
        assign p_sum   = 32'(ONE_Q30) - 32'(u3_reg) + 32'(uu_reg[2*DW-1:31]);
        assign m_prod  = 62'(rom4_reg) * 62'(p_reg);
        assign sh      = 6'd30 + 6'(k6_reg);
        assign lm_sh   = lm_reg >> sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                y_reg      <= y_prod[51:16];
                zero1_reg  <= (lam == '0) || q_ovf || (q >= EXP_ZERO_X);
                pen_n1_reg <= pen_n_next;

                u_reg      <= du_prod[DW+29:30];
                rom_reg    <= exp_rom[idx];
                k2_reg     <= y_reg[34:30];
                zero2_reg  <= zero1_reg || y_reg[35];
                pen_n2_reg <= pen_n1_reg;

                uu_reg     <= (2*DW)'(u_reg) * (2*DW)'(u_reg);
                u3_reg     <= u_reg;
                rom3_reg   <= rom_reg;
                k3_reg     <= k2_reg;
                zero3_reg  <= zero2_reg;
                pen_n3_reg <= pen_n2_reg;

                p_reg      <= p_sum[30:0];
                rom4_reg   <= rom3_reg;
                k4_reg     <= k3_reg;
                zero4_reg  <= zero3_reg;
                pen_n4_reg <= pen_n3_reg;

                m_reg      <= m_prod[60:30];
                k5_reg     <= k4_reg;
                zero5_reg  <= zero4_reg;
                pen_n5_reg <= pen_n4_reg;

                lm_reg     <= 62'(lam) * 62'(m_reg);
                k6_reg     <= k5_reg;
                zero6_reg  <= zero5_reg;
                pen_n6_reg <= pen_n5_reg;

                if (mode == MODE_EXP)
                    pen_reg <= zero6_reg ? '0 : lm_sh[30:0];
                else
                    pen_reg <= pen_n6_reg;
            end
        end

        assign pen_lvl[lv] = pen_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fp_reg <= 63'(pen_lvl[1]) * 63'(z_d_reg[LVL_LAST]);
            gn_reg <= gn_d_reg[LVL_LAST];
            gz_reg <= (gn_d_reg[LVL_LAST] == '0);
            pv_reg <= pen_lvl[0];
            pg_reg <= pen_lvl[1];
        end
    end

    sgpw_div #(.TAG_W(63)) u_fdiv
    (
        .clk     (clk),
        .en      (en),
        .num     (fp_reg),
        .den     (gn_reg),
        .tag     ({pv_reg, pg_reg, gz_reg}),
        .quot    (fq),
        .ovf     (fovf),
        .tag_out (ftag)
    );

    // ftag: pv [62:32], pg [31:1], zero group norm [0]
    assign sum_plain = 32'(ftag[62:32]) + 32'(ftag[31:1]);
    assign sum_div   = 32'(ftag[62:32]) + 32'(fq);

    always_comb
    begin
        if (ftag[0])
            penalty_next = sum_plain[31] ? PEN_MAX : sum_plain[30:0];
        else if (fovf || sum_div[31])
            penalty_next = PEN_MAX;
        else
            penalty_next = sum_div[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            penalty_reg <= penalty_next;
    end

    assign out_valid = out_valid_reg;
    assign penalty   = penalty_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sgpw_pkg::*;

    localparam logic [63:0] Q30_ONE  = 64'd1073741824;
    localparam logic [63:0] Q16_ONE  = 64'd65536;
    localparam logic [63:0] LOG2E    = 64'd1549082005;
    localparam logic [63:0] LN2      = 64'd744261118;
    localparam logic [63:0] X_FLOOR  = 64'd24 << 16;
    localparam logic [63:0] SAT31    = 64'h7FFF_FFFF;
    localparam int          TBITS    = 6;
    localparam int          N_PHASES = 14;
    localparam int          PHASE_N  = 46;
    localparam int          TIMEOUT  = 200000;

    typedef struct packed {
        logic signed [31:0] coef;
        logic signed [31:0] corr;
        logic [30:0]        gnorm;
        logic [30:0]        anorm;
    } beat_t;

    typedef struct packed {
        beat_t       b;
        logic [30:0] want;
    } known_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [30:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] old_coef;
    logic signed [31:0] correlation;
    logic [30:0]        group_norm;
    logic [30:0]        active_norm;
    logic               out_valid;
    logic               out_stall;
    logic [30:0]        penalty;

    // shadow of the block's registers
    logic [63:0] s_lambda_v, s_lambda_g, s_tau_v, s_tau_g, s_gamma_v, s_gamma_g;
    mode_t       s_mode_v, s_mode_g;

    logic [63:0] frac_rom [0:(1<<TBITS)-1];
    logic [30:0] pending_pen [$];
    logic [30:0] known_pen   [$];
    logic        known_chk   [$];
    int          errors;
    int          cycles = 0;
    logic        hold_req;
    logic        quiet;
    known_row_t  known_rows [0:7];

    sparse_group_penalty_weight #(.EXP_TABLE_BITS(TBITS)) dut (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [63:0] frac_entry(int i);
        logic [63:0] t, u, term, pos, neg;
        t    = 64'(i) << (30 - TBITS);
        u    = (t * LN2) >> 30;
        term = Q30_ONE;
        pos  = Q30_ONE;
        neg  = 0;
        for (int n = 1; n <= 14; n++)
        begin
            term = (term * u) >> 30;
            term = term / 64'(n);
            if (n % 2 == 1)
                neg += term;
            else
                pos += term;
        end
        if (neg > pos)
            return 0;
        pos -= neg;
        return (pos > Q30_ONE) ? Q30_ONE : pos;
    endfunction

    function automatic logic [63:0] exp_weight(logic [63:0] theta, logic [63:0] l,
                                               logic [63:0] tau);
        logic [63:0] x, y, k, f, d, u, p, m;
        if (l == 0)
            return 0;
        x = (tau * theta) / l;
        if (x >= X_FLOOR)
            return 0;
        y = (x * LOG2E) >> 16;
        k = y >> 30;
        if (k >= 32)
            return 0;
        f = y & (Q30_ONE - 1);
        d = f & ((64'd1 << (30 - TBITS)) - 1);
        u = (d * LN2) >> 30;
        p = Q30_ONE - u + ((u * u) >> 31);
        m = (frac_rom[f >> (30 - TBITS)] * p) >> 30;
        return (l * m) >> (30 + k);
    endfunction

    function automatic logic [63:0] level_weight(mode_t md, logic [63:0] theta,
                                                 logic [63:0] l, logic [63:0] g,
                                                 logic [63:0] tau);
        logic [63:0] th16;
        th16 = theta << 16;
        case (md)
            MODE_CONST: return l;
            MODE_MCP:   return (th16 < g * l) ? l - th16 / g : 0;
            MODE_EXP:   return exp_weight(theta, l, tau);
            default:
            begin
                if (theta <= l)
                    return l;
                if (th16 < l * g)
                    return (g * l - th16) / (g - Q16_ONE);
                return 0;
            end
        endcase
    endfunction

    function automatic logic [63:0] mag32(logic signed [31:0] v);
        return v[31] ? 64'h1_0000_0000 - 64'({1'b0, v}) : 64'({1'b0, v});
    endfunction

    function automatic logic [30:0] penalty_of(beat_t b);
        logic [63:0] pv, pg, sum;
        pv = level_weight(s_mode_v, mag32(b.coef), s_lambda_v, s_gamma_v, s_tau_v);
        pg = level_weight(s_mode_g, 64'(b.anorm), s_lambda_g, s_gamma_g, s_tau_g);
        if (b.gnorm != 0)
            pg = (pg * mag32(b.corr)) / 64'(b.gnorm);
        sum = pv + pg;
        return (sum > SAT31) ? SAT31[30:0] : sum[30:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // chk = 1: a hand-derived value stands beside the predicted one
    task automatic send_beat(beat_t b, logic chk, logic [30:0] want);
        @(negedge clk);
        old_coef    = b.coef;
        correlation = b.corr;
        group_norm  = b.gnorm;
        active_norm = b.anorm;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_pen.push_back(penalty_of(b));
        known_chk.push_back(chk);
        known_pen.push_back(want);
    endtask

    task automatic idle_in(int n);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [30:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_VAR_LAMBDA: s_lambda_v = 64'(val);
            REG_GRP_LAMBDA: s_lambda_g = 64'(val);
            REG_VAR_TAU:    s_tau_v    = 64'(val);
            REG_GRP_TAU:    s_tau_g    = 64'(val);
            REG_VAR_GAMMA:  s_gamma_v  = 64'(val);
            REG_GRP_GAMMA:  s_gamma_g  = 64'(val);
            REG_VAR_MODE:   s_mode_v   = mode_t'(val[1:0]);
            default:        s_mode_g   = mode_t'(val[1:0]);
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_pen.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [30:0] scaled31();
        return 31'($urandom >> $urandom_range(0, 31));
    endfunction

    function automatic logic [30:0] pick_lambda();
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'd65536;
            default: return 31'($urandom >> $urandom_range(8, 16));
        endcase
    endfunction

    function automatic logic [30:0] pick_gamma();
        case ($urandom_range(0, 7))
            0: return 31'd65537;
            1: return 31'h7FFF_FFFF;
            2: return 31'd0;
            3: return 31'd65536;
            default: return 31'd65537 + 31'($urandom_range(0, 1 << 20));
        endcase
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        b.coef  = $urandom_range(0, 1) ? -$signed({1'b0, scaled31()}) : {1'b0, scaled31()};
        b.corr  = $urandom_range(0, 1) ? -$signed({1'b0, scaled31()}) : {1'b0, scaled31()};
        if ($urandom_range(0, 15) == 0)
            b.coef = 32'sh8000_0000;
        b.gnorm = ($urandom_range(0, 7) == 0) ? 31'd0 : scaled31();
        b.anorm = scaled31();
        return b;
    endfunction

    // receiver: random stall bursts, a long hold on request, none when quiet
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (200) @(negedge clk);
                hold_req  = 1'b0;
                out_stall = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 4);
                out_stall = 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        logic [30:0] want;
        logic        chk;
        logic [30:0] typed;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pen.size() == 0)
                report_mismatch($sformatf("unexpected beat penalty=%h", penalty));
            else
            begin
                want  = pending_pen.pop_front();
                chk   = known_chk.pop_front();
                typed = known_pen.pop_front();
                if (penalty !== want)
                    report_mismatch($sformatf("penalty got %h want %h", penalty, want));
                if (chk && penalty !== typed)
                    report_mismatch($sformatf("penalty got %h table %h", penalty, typed));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT)
        begin
            $display("FAIL sparse_group_penalty_weight");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        hold_req    = 1'b0;
        quiet       = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        old_coef    = '0;
        correlation = '0;
        group_norm  = '0;
        active_norm = '0;
        for (int i = 0; i < (1 << TBITS); i++)
            frac_rom[i] = frac_entry(i);
        s_lambda_v = Q16_ONE;
        s_lambda_g = Q16_ONE;
        s_tau_v    = Q16_ONE;
        s_tau_g    = Q16_ONE;
        s_gamma_v  = 3 * Q16_ONE;
        s_gamma_g  = 3 * Q16_ONE;
        s_mode_v   = MODE_CONST;
        s_mode_g   = MODE_CONST;

        // reset registers: both levels give a flat 1.0
        known_rows[0] = '{'{32'sd0, 32'sd0, 31'd0, 31'd0}, 31'd131072};
        known_rows[1] = '{'{32'sh7FFF_FFFF, 32'sh8000_0000, 31'd0, 31'h7FFF_FFFF},
                          31'd131072};
        known_rows[2] = '{'{32'sh8000_0000, 32'sd65536, 31'd65536, 31'd0}, 31'd131072};
        known_rows[3] = '{'{32'sd1, 32'sd0, 31'd1, 31'h7FFF_FFFF}, 31'd65536};
        known_rows[4] = '{'{-32'sd1, 32'sh8000_0000, 31'd1, 31'd0}, 31'h7FFF_FFFF};
        known_rows[5] = '{'{32'sd0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'd5}, 31'd131072};
        known_rows[6] = '{'{32'sd123, 32'sd196608, 31'd65536, 31'd9}, 31'd262144};
        known_rows[7] = '{'{32'sd0, -32'sd65536, 31'd131072, 31'd0}, 31'd98304};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (known_rows[i])
            send_beat(known_rows[i].b, 1'b1, known_rows[i].want);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_VAR_LAMBDA, 31'd65536);
                    write_reg(REG_GRP_LAMBDA, 31'd131072);
                    write_reg(REG_VAR_GAMMA, 31'd196608);
                    write_reg(REG_GRP_GAMMA, 31'd65537);
                end
                1:
                begin
                    // gamma at or below one on both levels
                    write_reg(REG_VAR_GAMMA, 31'd0);
                    write_reg(REG_GRP_GAMMA, 31'd65536);
                end
                2:
                begin
                    // zero lambda and extreme tau, with MCP on the variable level and a constant group level
                    write_reg(REG_VAR_LAMBDA, 31'd0);
                    write_reg(REG_GRP_LAMBDA, 31'h7FFF_FFFF);
                    write_reg(REG_VAR_TAU, 31'h7FFF_FFFF);
                    write_reg(REG_GRP_TAU, 31'd0);
                end
                3:
                begin
                    write_reg(REG_VAR_LAMBDA, 31'h7FFF_FFFF);
                    write_reg(REG_GRP_LAMBDA, 31'd65536);
                    write_reg(REG_VAR_TAU, 31'd4096);
                    write_reg(REG_GRP_TAU, 31'd65536);
                    write_reg(REG_VAR_GAMMA, 31'h7FFF_FFFF);
                    write_reg(REG_GRP_GAMMA, 31'd65537);
                end
                default:
                begin
                    write_reg(REG_VAR_LAMBDA, pick_lambda());
                    write_reg(REG_GRP_LAMBDA, pick_lambda());
                    write_reg(REG_VAR_TAU, pick_lambda());
                    write_reg(REG_GRP_TAU, pick_lambda());
                    write_reg(REG_VAR_GAMMA, pick_gamma());
                    write_reg(REG_GRP_GAMMA, pick_gamma());
                end
            endcase
            // walk every mode on each level early, then random
            if (ph < 4)
            begin
                write_reg(REG_VAR_MODE, 31'(ph));
                write_reg(REG_GRP_MODE, 31'(3 - ph));
            end
            else
            begin
                write_reg(REG_VAR_MODE, 31'($urandom_range(0, 3)));
                write_reg(REG_GRP_MODE, 31'($urandom_range(0, 3)));
            end
            quiet = (ph == N_PHASES - 1);

            for (int i = 0; i < PHASE_N; i++)
            begin
                if (ph == 2 && i == 3)
                    hold_req = 1'b1;
                if (!quiet && !hold_req && $urandom_range(0, 3) == 0)
                    idle_in($urandom_range(1, 4));
                send_beat(random_beat(), 1'b0, '0);
            end
            drain();
        end

        if (errors == 0)
            $display("PASS sparse_group_penalty_weight");
        else
            $display("FAIL sparse_group_penalty_weight");
        $finish;
    end

endmodule

// ===== sim.f =====
design/sgpw_pkg.sv
design/sgpw_div.sv
design/sparse_group_penalty_weight.sv
tb/tb.sv
